### hw/rtl/cle_pkg.sv
// Shared types, constants and helpers for the console line editor.
// No dependencies.
package cle_pkg;

    localparam int LINE_MAX_DEFAULT = 32;
    localparam int DATA_W           = 8;
    localparam int LEN_W            = 6;
    localparam int KIND_W           = 2;
    localparam int CFG_INDEX_W      = 4;

    localparam logic [KIND_W-1:0] KIND_ECHO  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTER_KEY = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACK_KEY  = 4'd1;

    localparam logic [DATA_W-1:0] ENTER_KEY_RESET = 8'h0D;
    localparam logic [DATA_W-1:0] BACK_KEY_RESET  = 8'h08;

    localparam logic [DATA_W-1:0] CR_CODE      = 8'h0D;
    localparam logic [DATA_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [DATA_W-1:0] HIGH_A_END   = 8'hAF;
    localparam logic [DATA_W-1:0] HIGH_B_START = 8'hE0;
    localparam logic [DATA_W-1:0] HIGH_B_END   = 8'hF3;

    function automatic logic is_storable(input logic [DATA_W-1:0] b);
        logic ok;
        ok = 1'b1;
        if (b < SPACE_CODE) ok = 1'b0;
        if (b > HIGH_A_END && b < HIGH_B_START) ok = 1'b0;
        if (b > HIGH_B_END) ok = 1'b0;
        return ok;
    endfunction

endpackage

### hw/rtl/console_line_editor.sv
// Console line editor top level: line memory, sequencer and output register.
// Depends on cle_pkg and cle_ram.
//
// Takes one console byte per item and keeps the typed line in a LINE_MAX-entry
// memory. A storable byte is written and echoed (one result) while the line is
// not full; the back key on a non-empty line gives three echo results; enter or
// carriage return replays the stored line out of the memory read port, one
// character per cycle while out_ready holds high, or one empty-line result. An
// item that gives no result is dropped and the block stays ready; any other
// item holds in_ready low until its last result is registered. A new item is
// taken while the last result still waits in the output register. The line
// memory needs no clearing after reset.
module console_line_editor
    import cle_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DATA_W-1:0]      rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [KIND_W-1:0]      kind,
    output logic [DATA_W-1:0]      data_byte,
    output logic [LEN_W-1:0]       line_length,
    output logic                   last,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]      cfg_wdata
);

    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_ECHO = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    typedef enum logic [1:0] {
        M_CHAR,
        M_BACK,
        M_EMPTY
    } mode_t;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [DATA_W-1:0] byte_reg, byte_next;
    logic [DATA_W-1:0] enter_key_reg, back_key_reg;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic in_fire, slot_free, is_zero, is_enter, is_back, is_store, full;

    cle_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (LINE_MAX),
        .ADDR_W (AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign full      = (count_reg == CW'(LINE_MAX));

    assign is_zero  = (rx_byte == '0);
    assign is_enter = !is_zero && (rx_byte == enter_key_reg || rx_byte == CR_CODE);
    assign is_back  = !is_zero && !is_enter && (rx_byte == back_key_reg);
    assign is_store = !is_zero && !is_enter && !is_back && is_storable(rx_byte) && !full;

    assign ram_waddr = count_reg[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        data_next      = data_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    byte_next = rx_byte;
                    idx_next  = '0;
                    if (is_enter)
                    begin
                        n_next     = count_reg;
                        count_next = '0;
                        if (count_reg == '0)
                        begin
                            mode_next  = M_EMPTY;
                            state_next = ST_ECHO;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_DUMP;
                        end
                    end
                    else if (is_back)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                            mode_next  = M_BACK;
                            state_next = ST_ECHO;
                        end
                    end
                    else if (is_store)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        mode_next  = M_CHAR;
                        state_next = ST_ECHO;
                    end
                end
            end
            ST_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    len_next       = '0;
                    case (mode_reg)
                        M_BACK:
                        begin
                            kind_next = KIND_ECHO;
                            data_next = (idx_reg == CW'(1)) ? SPACE_CODE : back_key_reg;
                            last_next = (idx_reg == CW'(2));
                            idx_next  = idx_reg + 1'b1;
                            if (idx_reg == CW'(2))
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        M_EMPTY:
                        begin
                            kind_next  = KIND_EMPTY;
                            data_next  = '0;
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            kind_next  = KIND_ECHO;
                            data_next  = byte_reg;
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_LINE;
                    data_next      = ram_rdata;
                    len_next       = LEN_W'(n_reg);
                    last_next      = (idx_reg + 1'b1 == n_reg);
                    if (idx_reg + 1'b1 == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(idx_reg + 1'b1);
                        idx_next  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            enter_key_reg <= ENTER_KEY_RESET;
            back_key_reg  <= BACK_KEY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en && cfg_index == REG_ENTER_KEY)
            begin
                enter_key_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == REG_BACK_KEY)
            begin
                back_key_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        idx_reg  <= idx_next;
        n_reg    <= n_next;
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign line_length = len_reg;
    assign last        = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LINE_MAX))
        else $error("line count above capacity");

    a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_enter) |=> (count_reg == '0))
        else $error("line not cleared after enter");

    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (idx_reg < n_reg))
        else $error("replay index past line end");

    a_echo_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_ECHO) |-> (line_length == '0))
        else $error("echo item carries a line length");

endmodule

### hw/rtl/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
